>>> design/argb_alpha_over_blend_macros.svh
// Assertion helpers shared by the blend block.
`ifndef ARGB_ALPHA_OVER_BLEND_MACROS_SVH
`define ARGB_ALPHA_OVER_BLEND_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define AOB_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("blend assertion failed");

// Next-cycle implication, checked outside reset.
`define AOB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("blend assertion failed");

`endif

>>> design/aob_pkg.sv
`default_nettype none

package aob_pkg;

	localparam int QUO_BITS    = 8;
	localparam int DEN_W       = 16;
	localparam int REM_W       = 24;
	localparam int NUM_CH      = 3;
	localparam int ALPHA_SHIFT = 23;
	// Reciprocal of 255 scaled by 2^23, rounded up; exact for every divisor below 65026.
	localparam logic [DEN_W-1:0] ALPHA_RECIP = 16'h8081;
	localparam logic [7:0] ALPHA_ZERO = 8'h00;
	localparam logic [7:0] ALPHA_FULL = 8'hFF;
	// Two preparation stages, one stage per quotient bit, one output register.
	localparam int LATENCY = 2 + QUO_BITS + 1;

	typedef struct packed {
		logic                              bypass;
		logic [31:0]                       pass_pixel;
		logic [REM_W-1:0]                  dsh;
		logic [NUM_CH-1:0][REM_W-1:0]      rem;
		logic [NUM_CH-1:0][QUO_BITS-1:0]   quo;
		logic [7:0]                        alpha;
	} cell_t;

endpackage

`default_nettype wire

>>> design/aob_prep.sv
`default_nettype none

module aob_prep (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire logic [31:0]    source_pixel,
	input  wire logic [31:0]    dest_pixel,
	output logic                out_valid,
	output aob_pkg::cell_t      out_data
);

	logic [7:0]  sa;
	logic [7:0]  da;
	logic [7:0]  inv_sa;
	logic [15:0] sw;
	logic [15:0] dw;

	logic                               valid_s1;
	logic                               bypass_s1;
	logic [31:0]                        pass_s1;
	logic [aob_pkg::DEN_W-1:0]          sw_s1;
	logic [aob_pkg::DEN_W-1:0]          dw_s1;
	logic [aob_pkg::DEN_W-1:0]          den_s1;
	logic [aob_pkg::NUM_CH-1:0][7:0]    sc_s1;
	logic [aob_pkg::NUM_CH-1:0][7:0]    dc_s1;

	logic [31:0]                        alpha_prod;
	aob_pkg::cell_t                     next_cell;

	assign sa     = source_pixel[31:24];
	assign da     = dest_pixel[31:24];
	assign inv_sa = 8'hFF - sa;
	assign sw     = {sa, 8'h00} - {8'h00, sa};
	assign dw     = {8'h00, da} * {8'h00, inv_sa};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		bypass_s1 <= (sa == aob_pkg::ALPHA_ZERO) || (sa == aob_pkg::ALPHA_FULL);
		pass_s1   <= (sa == aob_pkg::ALPHA_ZERO) ? dest_pixel : source_pixel;
		sw_s1     <= sw;
		dw_s1     <= dw;
		den_s1    <= sw + dw;
		for (int c = 0; c < aob_pkg::NUM_CH; c++) begin
			sc_s1[c] <= source_pixel[c*8 +: 8];
			dc_s1[c] <= dest_pixel[c*8 +: 8];
		end
	end

	// Numerators and alpha; the first divider cell compares against den shifted up by 7.
	assign alpha_prod = {16'h0000, den_s1} * {16'h0000, aob_pkg::ALPHA_RECIP};

	always_comb begin
		next_cell            = '0;
		next_cell.bypass     = bypass_s1;
		next_cell.pass_pixel = pass_s1;
		next_cell.dsh        = {1'b0, den_s1, 7'b0};
		next_cell.alpha      = alpha_prod[aob_pkg::ALPHA_SHIFT +: 8];
		for (int c = 0; c < aob_pkg::NUM_CH; c++) begin
			next_cell.rem[c] = {16'h0000, sc_s1[c]} * {8'h00, sw_s1} +
				{16'h0000, dc_s1[c]} * {8'h00, dw_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		out_data <= next_cell;
	end

endmodule

`default_nettype wire

>>> design/aob_div_cell.sv
`default_nettype none

module aob_div_cell (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire aob_pkg::cell_t in_data,
	output logic                out_valid,
	output aob_pkg::cell_t      out_data
);

	aob_pkg::cell_t next_cell;

	// One restoring step: each channel's remainder against the shifted divisor.
	always_comb begin
		next_cell     = in_data;
		next_cell.dsh = {1'b0, in_data.dsh[aob_pkg::REM_W-1:1]};
		for (int c = 0; c < aob_pkg::NUM_CH; c++) begin
			if (in_data.rem[c] >= in_data.dsh) begin
				next_cell.rem[c] = in_data.rem[c] - in_data.dsh;
				next_cell.quo[c] = {in_data.quo[c][aob_pkg::QUO_BITS-2:0], 1'b1};
			end else begin
				next_cell.quo[c] = {in_data.quo[c][aob_pkg::QUO_BITS-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_data <= next_cell;
	end

endmodule

`default_nettype wire

>>> design/argb_alpha_over_blend.sv
// Channel   | Direction | Handshake           | Payload
// command   | in        | start, busy         | source_pixel[31:0], dest_pixel[31:0]
// result    | out       | done (one cycle)    | blended_pixel[31:0]
//
// One item is accepted every clock cycle; busy is never raised.
// Each result passes, after its item is accepted, through two preparation
// stages, eight divider cells (one quotient bit each), and one output register.
// Throughput is one item per cycle.
// Reset (arst_n low) clears only the valid bits; in-flight items are dropped.
// The receiver cannot stall, so no item ever waits inside the block.
`default_nettype none

`include "argb_alpha_over_blend_macros.svh"

module argb_alpha_over_blend (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [31:0] source_pixel,
	input  wire logic [31:0] dest_pixel,
	output logic             done,
	output logic [31:0]      blended_pixel
);

	// The pipeline never fills up, so the block is always ready for another item.
	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// Chain of valid bits and cell payloads: index 0 is the output of the
	// preparation stages, index QUO_BITS is the output of the last divider cell.
	logic           chain_valid [aob_pkg::QUO_BITS+1];
	aob_pkg::cell_t chain_data  [aob_pkg::QUO_BITS+1];

	// Preparation computes the channel weights, the divisor, the three numerators
	// and the output alpha (divisor over 255 by a reciprocal multiply).
	aob_prep u_prep (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (accept),
		.source_pixel (source_pixel),
		.dest_pixel   (dest_pixel),
		.out_valid    (chain_valid[0]),
		.out_data     (chain_data[0])
	);

	// Each cell resolves one quotient bit, most significant first, for the red,
	// green and blue channels at once, and hands the item to its neighbor.
	for (genvar i = 0; i < aob_pkg::QUO_BITS; i++) begin : g_cell
		aob_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[i]),
			.in_data   (chain_data[i]),
			.out_valid (chain_valid[i+1]),
			.out_data  (chain_data[i+1])
		);
	end

	aob_pkg::cell_t last_cell;
	logic [31:0]    result_pixel;

	assign last_cell = chain_data[aob_pkg::QUO_BITS];

	// Transparent or opaque sources skip the blend and carry the chosen pixel
	// through the chain untouched.
	assign result_pixel = last_cell.bypass ? last_cell.pass_pixel :
		{last_cell.alpha, last_cell.quo[2], last_cell.quo[1], last_cell.quo[0]};

	logic        done_q;
	logic [31:0] blended_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= chain_valid[aob_pkg::QUO_BITS];
		end
	end

	always_ff @(posedge clk) begin
		blended_q <= result_pixel;
	end

	assign done          = done_q;
	assign blended_pixel = blended_q;

	// A result only comes from an item that was accepted.
	`AOB_ASSERT_IMPL(a_done_from_start, done, $past(start, aob_pkg::LATENCY))
	// A transparent source returns the destination unchanged.
	`AOB_ASSERT_IMPL(a_transparent_pass, done && ($past(source_pixel[31:24], aob_pkg::LATENCY) == aob_pkg::ALPHA_ZERO), blended_pixel == $past(dest_pixel, aob_pkg::LATENCY))
	// An opaque source replaces the destination.
	`AOB_ASSERT_IMPL(a_opaque_pass, done && ($past(source_pixel[31:24], aob_pkg::LATENCY) == aob_pkg::ALPHA_FULL), blended_pixel == $past(source_pixel, aob_pkg::LATENCY))
	// Blended coverage never falls below the source coverage.
	`AOB_ASSERT_IMPL(a_alpha_floor, done, blended_pixel[31:24] >= $past(source_pixel[31:24], aob_pkg::LATENCY) || $past(source_pixel[31:24], aob_pkg::LATENCY) == aob_pkg::ALPHA_ZERO)
	// The block never refuses an item.
	`AOB_ASSERT_NEXT(a_never_busy, start, !busy)

endmodule

`default_nettype wire

>>> sim/argb_alpha_over_blend_tb.sv
`default_nettype none

// Holds the composites that are still owed by the block, in the order their
// pixel pairs went in, and compares every result strobe against the oldest one.
class over_composite_board;
	bit [31:0] owed_pixels[$];
	int unsigned mismatches;
	int unsigned results_seen;

	function new();
		mismatches = 0;
		results_seen = 0;
	endfunction

	// Straight-alpha blend of one channel, weighted by each layer's coverage.
	static function bit [7:0] mix_channel(bit [7:0] s, bit [7:0] d, int unsigned sw,
		int unsigned dw, int unsigned den);
		int unsigned q;
		q = (s * sw + d * dw) / den;
		return q[7:0];
	endfunction

	// Source-over of one upper pixel onto one lower pixel.
	static function bit [31:0] composite_over(bit [31:0] src, bit [31:0] dst);
		int unsigned sa, da, sw, dw, den, a;
		bit [7:0] r, g, b;
		if (src[31:24] == aob_pkg::ALPHA_ZERO)
			return dst;
		if (src[31:24] == aob_pkg::ALPHA_FULL)
			return src;
		sa = src[31:24];
		da = dst[31:24];
		sw = sa * 255;
		dw = da * (255 - sa);
		den = sw + dw;
		r = mix_channel(src[23:16], dst[23:16], sw, dw, den);
		g = mix_channel(src[15:8], dst[15:8], sw, dw, den);
		b = mix_channel(src[7:0], dst[7:0], sw, dw, den);
		a = den / 255;
		return {a[7:0], r, g, b};
	endfunction

	function void note_pair(bit [31:0] src, bit [31:0] dst);
		owed_pixels.push_back(composite_over(src, dst));
	endfunction

	function void check_pixel(bit [31:0] got, longint unsigned stamp);
		bit [31:0] want;
		results_seen++;
		if (owed_pixels.size() == 0) begin
			mismatches++;
			$display("%0t: unexpected result strobe, expected none, actual %08h", stamp, got);
			return;
		end
		want = owed_pixels.pop_front();
		if (got !== want) begin
			mismatches++;
			$display("%0t: blended_pixel expected %08h actual %08h", stamp, want, got);
		end
	endfunction

	function int unsigned still_owed();
		return owed_pixels.size();
	endfunction
endclass

module argb_alpha_over_blend_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// A stall this long with no item and no result means the block has hung.
	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned RANDOM_ITEMS = 725;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [31:0] source_pixel;
	logic [31:0] dest_pixel;
	logic        done;
	logic [31:0] blended_pixel;

	over_composite_board board;

	// When set, the driver drops start on roughly a third of the cycles.
	bit          idle_gaps;
	int unsigned items_in;
	int unsigned transparent_in;
	int unsigned opaque_in;
	int unsigned mixed_in;
	int unsigned stall_cycles;

	argb_alpha_over_blend uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.source_pixel (source_pixel),
		.dest_pixel   (dest_pixel),
		.done         (done),
		.blended_pixel(blended_pixel)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Everything happens at the rising edge: an item counts as taken when start
	// is high and busy is low, and a result counts when done is high. Inputs
	// are only ever changed at the falling edge, so both are stable here.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				board.note_pair(source_pixel, dest_pixel);
				items_in++;
				if (source_pixel[31:24] == aob_pkg::ALPHA_ZERO)
					transparent_in++;
				else if (source_pixel[31:24] == aob_pkg::ALPHA_FULL)
					opaque_in++;
				else
					mixed_in++;
			end
			if (done)
				board.check_pixel(blended_pixel, $time);
			// The watchdog restarts whenever either side of the block moves.
			if ((start && !busy) || done)
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles, %0d results still owed",
					$time, stall_cycles, board.still_owed());
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// Presents one pixel pair and holds it until the block takes it. Idle
	// cycles, when enabled, are inserted ahead of the item with start low.
	task automatic send_pair(input logic [31:0] src, input logic [31:0] dst);
		@(negedge clk);
		while (idle_gaps && $urandom_range(0, 99) < 32) begin
			start <= 1'b0;
			source_pixel <= $urandom();
			dest_pixel <= $urandom();
			@(negedge clk);
		end
		start <= 1'b1;
		source_pixel <= src;
		dest_pixel <= dst;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Alpha values lean on the two bypass codes and on the edges of the
	// blended range, since that is where the divider is most likely to slip.
	function automatic logic [7:0] pick_alpha();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 15)
			return aob_pkg::ALPHA_ZERO;
		else if (roll < 30)
			return aob_pkg::ALPHA_FULL;
		else if (roll < 36)
			return 8'd1;
		else if (roll < 42)
			return 8'd254;
		else
			return 8'($urandom_range(0, 255));
	endfunction

	initial begin
		int unsigned n;
		logic [31:0] src_word;
		logic [31:0] dst_word;

		board = new();
		idle_gaps = 1'b0;
		items_in = 0;
		transparent_in = 0;
		opaque_in = 0;
		mixed_in = 0;
		stall_cycles = 0;
		arst_n <= 1'b0;
		start <= 1'b0;
		source_pixel <= '0;
		dest_pixel <= '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part. A transparent source must pass the destination through
		// untouched and an opaque one must replace it, whatever the colors.
		send_pair(32'h00000000, 32'h00000000);
		send_pair(32'h00FFFFFF, 32'h12345678);
		send_pair(32'h00ABCDEF, 32'hFFFFFFFF);
		send_pair(32'hFF000000, 32'hFFFFFFFF);
		send_pair(32'hFFFFFFFF, 32'h00000000);
		send_pair(32'hFF5A3C1E, 32'h80C0FFEE);
		// Partial source over a fully transparent destination must give back
		// the source colors with alpha equal to the source alpha.
		send_pair(32'h01FFFFFF, 32'h00000000);
		send_pair(32'hFE123456, 32'h00FFFFFF);
		send_pair(32'h80A5A5A5, 32'h005A5A5A);
		// Smallest, middle and largest partial alpha against opaque, faint and transparent
		// layers, mostly with channels at opposite extremes so the weighting shows.
		send_pair(32'h01FFFFFF, 32'hFF000000);
		send_pair(32'h01000000, 32'hFFFFFFFF);
		send_pair(32'hFEFFFFFF, 32'hFF000000);
		send_pair(32'hFE000000, 32'hFFFFFFFF);
		send_pair(32'h01FFFFFF, 32'h01000000);
		send_pair(32'hFE00FF00, 32'h01FF00FF);
		send_pair(32'h80FF00FF, 32'hFF00FF00);
		send_pair(32'h7F000000, 32'h80FFFFFF);
		send_pair(32'h80FFFFFF, 32'hFFFFFFFF);
		send_pair(32'h80000000, 32'h00000000);
		send_pair(32'h55AA55AA, 32'hAA55AA55);
		send_pair(32'hAA55AA55, 32'h55AA55AA);

		// Random part. The middle stretch (items 250 to 449) runs back to back with no
		// gaps so the pipeline is kept completely full.
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			idle_gaps = !(n >= 250 && n < 450);
			src_word = {pick_alpha(), 24'($urandom())};
			dst_word = {pick_alpha(), 24'($urandom())};
			send_pair(src_word, dst_word);
		end

		@(negedge clk);
		start <= 1'b0;

		// Drain: wait for every owed composite, then keep the clock running so that
		// any stray strobe after the last one is still caught.
		while (board.still_owed() != 0)
			@(posedge clk);
		repeat (aob_pkg::LATENCY + 4) @(posedge clk);

		$display("Blended %0d pixel pairs: %0d transparent, %0d opaque, %0d partial source.",
			items_in, transparent_in, opaque_in, mixed_in);
		$display("Checked %0d composites, %0d of them wrong.", board.results_seen,
			board.mismatches);
		if (board.mismatches == 0 && board.still_owed() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire

>>> argb_alpha_over_blend.f
+incdir+design
design/aob_pkg.sv
design/aob_prep.sv
design/aob_div_cell.sv
design/argb_alpha_over_blend.sv
sim/argb_alpha_over_blend_tb.sv
